/* rtl/splu_pkg.sv */
// Shared types and constants for the site partial likelihood update block.
// Used by every module under rtl; depends on nothing else.
package splu_pkg;

	// Product width used by the shared rounding stage.
	localparam int PROD_W = 106;
	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	// Latency of the back pipeline in enabled cycles.
	localparam int BACK_LAT = 20;
	// Point in the back pipeline where the final multiply takes its operands.
	localparam int FINAL_TAP = 14;
	// Default quiet NaN produced by an invalid operation.
	localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
	localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_LEFT_DIAG  = 2'd0,
		CFG_LEFT_OFF   = 2'd1,
		CFG_RIGHT_DIAG = 2'd2,
		CFG_RIGHT_OFF  = 2'd3
	} cfg_index_t;

	// One site as it arrives.
	typedef struct packed {
		logic [2:0]  left_select;
		logic [63:0] left_a;
		logic [63:0] left_c;
		logic [63:0] left_g;
		logic [63:0] left_t;
		logic [2:0]  right_select;
		logic [63:0] right_a;
		logic [63:0] right_c;
		logic [63:0] right_g;
		logic [63:0] right_t;
		logic        last_site;
	} site_in_t;

	// One parent result.
	typedef struct packed {
		logic [63:0] parent_a;
		logic [63:0] parent_c;
		logic [63:0] parent_g;
		logic [63:0] parent_t;
		logic        last_out;
	} site_out_t;

	// Classification of one site, kept alongside the data.
	typedef struct packed {
		logic       left_tip;
		logic [1:0] left_state;
		logic       right_tip;
		logic [1:0] right_state;
		logic       last;
	} site_tag_t;

	// A classified site as held in the queue.
	typedef struct packed {
		site_tag_t        tag;
		logic [3:0][63:0] left_vec;
		logic [3:0][63:0] right_vec;
	} site_item_t;

	// Operand of the shared rounding stage: value is mag * 2^exp.
	typedef struct packed {
		logic               sign;
		logic [PROD_W-1:0]  mag;
		logic signed [12:0] exp;
		logic               spec;
		logic [63:0]        spec_bits;
	} rnd_in_t;

	function automatic logic is_nan(input logic [63:0] x);
		return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
	endfunction

	function automatic logic is_inf(input logic [63:0] x);
		return (x[62:52] == 11'h7FF) && (x[51:0] == 52'd0);
	endfunction

endpackage

/* rtl/splu_round.sv */
// Normalize, round to nearest even and pack a double from an exact significand.
// Three pipeline stages; depends on splu_pkg.
module splu_round import splu_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  rnd_in_t     rin,
	output logic [63:0] res
);

	rnd_in_t            a_s1;
	logic [6:0]         msb_s1;
	logic [6:0]         msb_c;

	logic               sign_s2;
	logic [PROD_W-1:0]  mag_s2;
	logic               zero_s2;
	logic               spec_s2;
	logic [63:0]        spec_bits_s2;
	logic [7:0]         sh_s2;
	logic [11:0]        ulpb_s2;

	logic signed [13:0] mm52_c;
	logic signed [13:0] lim_c;
	logic signed [13:0] r_c;
	logic signed [13:0] ulp_c;
	logic [7:0]         sh_c;

	logic [169:0]       x_c;
	logic [169:0]       t_c;
	logic [169:0]       back_c;
	logic               lost_c;
	logic [53:0]        q0_c;
	logic [53:0]        q_c;
	logic               up_c;
	logic [64:0]        sum_c;
	logic [63:0]        res_c;

	// Leading one position of the significand.
	always_comb begin
		msb_c = 7'd0;
		for (int i = 0; i < PROD_W; i++) begin
			if (rin.mag[i]) begin
				msb_c = 7'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= rin;
			msb_s1 <= msb_c;
		end
	end

	// Choose the unit in the last place, clamped at the denormal limit.
	always_comb begin
		mm52_c = $signed({7'd0, msb_s1}) - 14'sd52;
		lim_c  = -14'sd1074 - 14'(a_s1.exp);
		r_c    = (mm52_c > lim_c) ? mm52_c : lim_c;
		ulp_c  = 14'(a_s1.exp) + r_c;
		if (r_c > 14'sd120) begin
			sh_c = 8'd184;
		end else begin
			sh_c = 8'(r_c + 14'sd64);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sign_s2      <= a_s1.sign;
			mag_s2       <= a_s1.mag;
			zero_s2      <= (a_s1.mag == '0);
			spec_s2      <= a_s1.spec;
			spec_bits_s2 <= a_s1.spec_bits;
			sh_s2        <= sh_c;
			ulpb_s2      <= 12'(ulp_c + 14'sd1074);
		end
	end

	// Shift into place, keep guard and sticky, round and pack.
	always_comb begin
		x_c    = {mag_s2, 64'd0};
		t_c    = x_c >> (sh_s2 - 8'd2);
		back_c = t_c << (sh_s2 - 8'd2);
		lost_c = (back_c != x_c);
		q0_c   = t_c[55:2];
		up_c   = t_c[1] & (t_c[0] | lost_c | q0_c[0]);
		q_c    = q0_c + {53'd0, up_c};
		sum_c  = {1'b0, ulpb_s2, 52'd0} + {11'd0, q_c};
		if (spec_s2) begin
			res_c = spec_bits_s2;
		end else if (zero_s2) begin
			res_c = {sign_s2, 63'd0};
		end else if (sum_c[64:52] >= 13'd2047) begin
			res_c = {sign_s2, 11'h7FF, 52'd0};
		end else begin
			res_c = {sign_s2, sum_c[62:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res <= res_c;
		end
	end

endmodule

/* rtl/splu_fmul.sv */
// Pipelined IEEE double multiplier, five stages, round to nearest even.
// Depends on splu_pkg and splu_round.
module splu_fmul import splu_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] res
);

	logic [52:0]        ma_c;
	logic [52:0]        mb_c;
	logic [10:0]        ea_c;
	logic [10:0]        eb_c;
	logic               sign_c;
	logic               spec_c;
	logic [63:0]        spec_bits_c;

	logic [53:0]        hh_s1;
	logic [52:0]        hl_s1;
	logic [52:0]        lh_s1;
	logic [51:0]        ll_s1;
	logic signed [12:0] exp_s1;
	logic               sign_s1;
	logic               spec_s1;
	logic [63:0]        spec_bits_s1;

	rnd_in_t            rnd_s2;
	logic [PROD_W-1:0]  prod_c;

	// Unpack and resolve special operands.
	always_comb begin
		ma_c   = {a[62:52] != 11'd0, a[51:0]};
		mb_c   = {b[62:52] != 11'd0, b[51:0]};
		ea_c   = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
		eb_c   = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];
		sign_c = a[63] ^ b[63];
		spec_c = 1'b1;
		if (is_nan(a)) begin
			spec_bits_c = a | QUIET_BIT;
		end else if (is_nan(b)) begin
			spec_bits_c = b | QUIET_BIT;
		end else if ((is_inf(a) && (b[62:0] == 63'd0)) ||
		             (is_inf(b) && (a[62:0] == 63'd0))) begin
			spec_bits_c = DEFAULT_NAN;
		end else if (is_inf(a) || is_inf(b)) begin
			spec_bits_c = {sign_c, 11'h7FF, 52'd0};
		end else begin
			spec_bits_c = 64'd0;
			spec_c      = 1'b0;
		end
	end

	// Four partial products of the split significands.
	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1        <= 54'(ma_c[52:26] * mb_c[52:26]);
			hl_s1        <= 53'(ma_c[52:26] * mb_c[25:0]);
			lh_s1        <= 53'(ma_c[25:0] * mb_c[52:26]);
			ll_s1        <= 52'(ma_c[25:0] * mb_c[25:0]);
			exp_s1       <= 13'($signed({2'b0, ea_c}) + $signed({2'b0, eb_c}) - 13'sd2150);
			sign_s1      <= sign_c;
			spec_s1      <= spec_c;
			spec_bits_s1 <= spec_bits_c;
		end
	end

	// Sum the partial products into the full significand product.
	assign prod_c = ({52'd0, hh_s1} << 52) + ({53'd0, hl_s1} << 26) +
	                ({53'd0, lh_s1} << 26) + {54'd0, ll_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			rnd_s2.sign      <= sign_s1;
			rnd_s2.mag       <= prod_c;
			rnd_s2.exp       <= exp_s1;
			rnd_s2.spec      <= spec_s1;
			rnd_s2.spec_bits <= spec_bits_s1;
		end
	end

	splu_round u_round (
		.clk (clk),
		.en  (en),
		.rin (rnd_s2),
		.res (res)
	);

endmodule

/* rtl/splu_fadd.sv */
// Pipelined IEEE double adder, five stages, round to nearest even.
// Depends on splu_pkg and splu_round.
module splu_fadd import splu_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] res
);

	logic               swap_c;
	logic [63:0]        x_c;
	logic [63:0]        y_c;
	logic [10:0]        ex_c;
	logic [10:0]        ey_c;
	logic [10:0]        d_c;
	logic [5:0]         dc_c;
	logic [55:0]        bigm_c;
	logic [55:0]        smm_c;
	logic [55:0]        shd_c;
	logic               lost_c;
	logic               spec_c;
	logic [63:0]        spec_bits_c;

	logic [55:0]        big_s1;
	logic [55:0]        small_s1;
	logic               sub_s1;
	logic               sign_s1;
	logic               zsign_s1;
	logic signed [12:0] exp_s1;
	logic               spec_s1;
	logic [63:0]        spec_bits_s1;

	logic [56:0]        sum_c;
	rnd_in_t            rnd_s2;

	// Order the operands by magnitude and align the smaller one with sticky.
	always_comb begin
		swap_c = (b[62:0] > a[62:0]);
		x_c    = swap_c ? b : a;
		y_c    = swap_c ? a : b;
		ex_c   = (x_c[62:52] == 11'd0) ? 11'd1 : x_c[62:52];
		ey_c   = (y_c[62:52] == 11'd0) ? 11'd1 : y_c[62:52];
		d_c    = ex_c - ey_c;
		dc_c   = (d_c >= 11'd56) ? 6'd56 : d_c[5:0];
		bigm_c = {x_c[62:52] != 11'd0, x_c[51:0], 3'd0};
		smm_c  = {y_c[62:52] != 11'd0, y_c[51:0], 3'd0};
		shd_c  = smm_c >> dc_c;
		lost_c = ((shd_c << dc_c) != smm_c);
		spec_c = 1'b1;
		if (is_nan(a)) begin
			spec_bits_c = a | QUIET_BIT;
		end else if (is_nan(b)) begin
			spec_bits_c = b | QUIET_BIT;
		end else if (is_inf(a) && is_inf(b) && (a[63] != b[63])) begin
			spec_bits_c = DEFAULT_NAN;
		end else if (is_inf(a)) begin
			spec_bits_c = a;
		end else if (is_inf(b)) begin
			spec_bits_c = b;
		end else begin
			spec_bits_c = 64'd0;
			spec_c      = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			big_s1       <= bigm_c;
			small_s1     <= {shd_c[55:1], shd_c[0] | lost_c};
			sub_s1       <= x_c[63] ^ y_c[63];
			sign_s1      <= x_c[63];
			zsign_s1     <= a[63] & b[63];
			exp_s1       <= 13'($signed({2'b0, ex_c}) - 13'sd1127);
			spec_s1      <= spec_c;
			spec_bits_s1 <= spec_bits_c;
		end
	end

	// Add or subtract the aligned significands; an exact zero takes its own sign.
	assign sum_c = sub_s1 ? ({1'b0, big_s1} - {1'b0, small_s1}) :
	                        ({1'b0, big_s1} + {1'b0, small_s1});

	always_ff @(posedge clk) begin
		if (en) begin
			rnd_s2.sign      <= (sum_c == 57'd0) ? zsign_s1 : sign_s1;
			rnd_s2.mag       <= {sum_c, 49'd0};
			rnd_s2.exp       <= exp_s1;
			rnd_s2.spec      <= spec_s1;
			rnd_s2.spec_bits <= spec_bits_s1;
		end
	end

	splu_round u_round (
		.clk (clk),
		.en  (en),
		.rin (rnd_s2),
		.res (res)
	);

endmodule

/* rtl/splu_front.sv */
// Front end: accepts sites, classifies each child as tip or inner, and queues them.
// Depends on splu_pkg.
module splu_front import splu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  site_in_t   in_data,
	output logic       head_valid,
	output site_item_t head,
	input  logic       pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	site_item_t       item_s1;
	logic             valid_s1;
	site_item_t       item_c;
	logic             accept;
	logic             push;
	logic             full;

	site_item_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// A select with its top bit clear names a tip state.
	always_comb begin
		item_c.tag.left_tip    = ~in_data.left_select[2];
		item_c.tag.left_state  = in_data.left_select[1:0];
		item_c.tag.right_tip   = ~in_data.right_select[2];
		item_c.tag.right_state = in_data.right_select[1:0];
		item_c.tag.last        = in_data.last_site;
		item_c.left_vec        = {in_data.left_t, in_data.left_g,
		                          in_data.left_c, in_data.left_a};
		item_c.right_vec       = {in_data.right_t, in_data.right_g,
		                          in_data.right_c, in_data.right_a};
	end

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push     = valid_s1 & ~full;
	assign in_stall = valid_s1 & full;
	assign accept   = in_valid & ~in_stall;

	// Classified beat waits here until the queue has room.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_c;
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_s1;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

endmodule

/* rtl/splu_back.sv */
// Back end: matrix-vector products, pairwise sums and the final elementwise product.
// Depends on splu_pkg, splu_fmul and splu_fadd.
module splu_back import splu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  site_item_t  head,
	output logic        pop,
	input  logic [63:0] left_diag,
	input  logic [63:0] left_off,
	input  logic [63:0] right_diag,
	input  logic [63:0] right_off,
	output logic        out_valid,
	input  logic        out_stall,
	output site_out_t   out_data
);

	logic              en;
	logic [BACK_LAT-1:0] v_q;
	site_tag_t         tag_q [BACK_LAT];

	logic [63:0]       diag_v [2];
	logic [63:0]       off_v  [2];
	logic [3:0][63:0]  vec_v  [2];
	logic [63:0]       pd   [2][4];
	logic [63:0]       po   [2][4];
	logic [63:0]       s01  [2][4];
	logic [63:0]       s23  [2][4];
	logic [63:0]       tot  [2][4];
	logic [63:0]       fac  [2][4];
	logic [63:0]       prod [4];
	logic              tip_v   [2];
	logic [1:0]        state_v [2];

	// The whole pipeline holds while a finished result is refused.
	assign en  = ~(v_q[BACK_LAT-1] & out_stall);
	assign pop = head_valid & en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[BACK_LAT-2:0], head_valid};
		end
	end

	// Classification travels beside the arithmetic.
	always_ff @(posedge clk) begin
		if (en) begin
			tag_q[0] <= head.tag;
			for (int i = 1; i < BACK_LAT; i++) begin
				tag_q[i] <= tag_q[i-1];
			end
		end
	end

	assign diag_v[0]  = left_diag;
	assign diag_v[1]  = right_diag;
	assign off_v[0]   = left_off;
	assign off_v[1]   = right_off;
	assign vec_v[0]   = head.left_vec;
	assign vec_v[1]   = head.right_vec;
	assign tip_v[0]   = tag_q[FINAL_TAP].left_tip;
	assign tip_v[1]   = tag_q[FINAL_TAP].right_tip;
	assign state_v[0] = tag_q[FINAL_TAP].left_state;
	assign state_v[1] = tag_q[FINAL_TAP].right_state;

	for (genvar s = 0; s < 2; s++) begin : g_side
		// Each likelihood meets the diagonal and the off-diagonal value once.
		for (genvar k = 0; k < 4; k++) begin : g_mul
			splu_fmul u_mul_d (
				.clk (clk), .en (en), .a (diag_v[s]), .b (vec_v[s][k]), .res (pd[s][k])
			);
			splu_fmul u_mul_o (
				.clk (clk), .en (en), .a (off_v[s]), .b (vec_v[s][k]), .res (po[s][k])
			);
		end
		// Row sums in pairs, then the two pairs.
		for (genvar r = 0; r < 4; r++) begin : g_row
			splu_fadd u_add01 (
				.clk (clk), .en (en),
				.a   ((r == 0) ? pd[s][0] : po[s][0]),
				.b   ((r == 1) ? pd[s][1] : po[s][1]),
				.res (s01[s][r])
			);
			splu_fadd u_add23 (
				.clk (clk), .en (en),
				.a   ((r == 2) ? pd[s][2] : po[s][2]),
				.b   ((r == 3) ? pd[s][3] : po[s][3]),
				.res (s23[s][r])
			);
			splu_fadd u_add_tot (
				.clk (clk), .en (en), .a (s01[s][r]), .b (s23[s][r]), .res (tot[s][r])
			);
			// A tip child contributes the matrix row of its state.
			assign fac[s][r] = !tip_v[s] ? tot[s][r] :
			                   (state_v[s] == 2'(r)) ? diag_v[s] : off_v[s];
		end
	end

	// Elementwise product of the two factors.
	for (genvar r = 0; r < 4; r++) begin : g_final
		splu_fmul u_mul_final (
			.clk (clk), .en (en), .a (fac[0][r]), .b (fac[1][r]), .res (prod[r])
		);
	end

	assign out_valid         = v_q[BACK_LAT-1];
	assign out_data.parent_a = prod[0];
	assign out_data.parent_c = prod[1];
	assign out_data.parent_g = prod[2];
	assign out_data.parent_t = prod[3];
	assign out_data.last_out = tag_q[BACK_LAT-1].last;

endmodule

/* rtl/site_partial_likelihood_update_top.sv */
// Top level of the site partial likelihood update block.
// Depends on splu_pkg, splu_front and splu_back.
//
// The block takes one site per clock cycle while in_stall is low and gives one
// parent result per site, in order. A site runs through a classify register, a
// four-entry queue and a twenty-stage floating-point pipeline (multiply, two
// levels of pairwise add, final multiply, each five stages). A stall at the
// output holds the whole arithmetic pipeline; the queue keeps taking sites until
// it fills. The user must write the four matrix registers through the
// configuration port only while no site is in flight; the block itself does not
// enforce this.
module site_partial_likelihood_update_top import splu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  site_in_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output site_out_t   out_data,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] left_diag_q;
	logic [63:0] left_off_q;
	logic [63:0] right_diag_q;
	logic [63:0] right_off_q;
	logic        head_valid;
	site_item_t  head;
	logic        pop;

	// Matrix registers; reset gives the identity matrix.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_diag_q  <= 64'h3FF0_0000_0000_0000;
			left_off_q   <= 64'd0;
			right_diag_q <= 64'h3FF0_0000_0000_0000;
			right_off_q  <= 64'd0;
		end else if (cfg_write) begin
			case (cfg_index_t'(cfg_index))
				CFG_LEFT_DIAG:  left_diag_q  <= cfg_data;
				CFG_LEFT_OFF:   left_off_q   <= cfg_data;
				CFG_RIGHT_DIAG: right_diag_q <= cfg_data;
				CFG_RIGHT_OFF:  right_off_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	splu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	splu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.left_diag  (left_diag_q),
		.left_off   (left_off_q),
		.right_diag (right_diag_q),
		.right_off  (right_off_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule
